[sv/assert_macros.svh]
// Assertion helpers shared by the RTL; clocked on clk, held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Boolean condition must never be seen
`define ASSERT_NEVER(label, expr, msg) `ASSERT_ALWAYS(label, !(expr), msg)

`endif

[sv/ieq_pkg.sv]
package ieq_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // Request codes
  localparam logic [2:0] REQ_TOUCH  = 3'd0;
  localparam logic [2:0] REQ_BUTTON = 3'd1;
  localparam logic [2:0] REQ_IMU    = 3'd2;
  localparam logic [2:0] REQ_READ   = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // Event kinds
  localparam logic [2:0] KIND_TOUCH  = 3'd0;
  localparam logic [2:0] KIND_BTN_A  = 3'd1;
  localparam logic [2:0] KIND_BTN_B  = 3'd2;
  localparam logic [2:0] KIND_BTN_C  = 3'd3;
  localparam logic [2:0] KIND_MOVED  = 3'd4;
  localparam logic [2:0] KIND_SHAKE  = 3'd5;

  // Register indexes
  localparam logic [2:0] CFG_TOUCH_HOLDOFF  = 3'd0;
  localparam logic [2:0] CFG_BUTTON_HOLDOFF = 3'd1;
  localparam logic [2:0] CFG_IMU_HOLDOFF    = 3'd2;
  localparam logic [2:0] CFG_MOVED_ACCEL    = 3'd3;
  localparam logic [2:0] CFG_SHAKE_ACCEL    = 3'd4;
  localparam logic [2:0] CFG_MOVED_GYRO     = 3'd5;
  localparam logic [2:0] CFG_SHAKE_GYRO     = 3'd6;

  // Register reset values
  localparam logic [15:0] RST_TOUCH_HOLDOFF  = 16'd200;
  localparam logic [15:0] RST_BUTTON_HOLDOFF = 16'd200;
  localparam logic [15:0] RST_IMU_HOLDOFF    = 16'd1000;
  localparam logic [11:0] RST_MOVED_ACCEL    = 12'd819;
  localparam logic [11:0] RST_SHAKE_ACCEL    = 12'd2662;
  localparam logic [14:0] RST_MOVED_GYRO     = 15'd560;
  localparam logic [14:0] RST_SHAKE_GYRO     = 15'd2240;

  // One g in Q4.12
  localparam logic [16:0] ONE_G = 17'd4096;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_MOTION,
    S_DONE
  } state_t;

  // One ring entry as stored in the event memory
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] stamp;
    logic [2:0]  kind;
    logic [31:0] coords;
  } ring_entry_t;

  localparam int ENTRY_W = $bits(ring_entry_t);

  // Motion thresholds handed to the classifier
  typedef struct packed {
    logic [11:0] moved_delta;
    logic [11:0] shake_delta;
    logic [14:0] moved_rate;
    logic [14:0] shake_rate;
  } motion_cfg_t;

  // Classifier status back to the controller
  typedef struct packed {
    logic busy;
    logic done;
    logic moving;
    logic shake;
  } motion_status_t;

  // Captured input beat
  typedef struct packed {
    logic [2:0]         req;
    logic [31:0]        now;
    logic [1:0]         valid;
    logic [2:0]         held;
    logic [2:0]         click;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic [3:0]         idx;
  } item_t;

  // Hold-off check: a last time of zero means never
  function automatic logic time_passed(input logic [31:0] now, input logic [31:0] last,
                                       input logic [15:0] holdoff);
    logic [31:0] diff;
    diff = now - last;
    return (last == 32'd0) || (diff >= {16'd0, holdoff});
  endfunction

endpackage

[sv/ieq_ram.sv]
module ieq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/ieq_motion.sv]
module ieq_motion
  import ieq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               gyro_ok,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  input  logic signed [15:0] rx,
  input  logic signed [15:0] ry,
  input  logic signed [15:0] rz,
  input  motion_cfg_t        cfg,
  output motion_status_t     status
);

  // Twelve squares go through one squarer; the product is consumed one step later
  localparam logic [3:0] STEP_DONE = 4'd13;

  logic               busy_r;
  logic [3:0]         step_r;
  logic [3:0]         tag;
  logic signed [16:0] op;
  logic signed [33:0] sq;
  logic [30:0]        prod_r;
  logic [31:0]        acc_r;
  logic [31:0]        gyr_r;
  logic               moved_r;
  logic               shake_r;

  // Pick the operand for this step
  always_comb begin
    case (step_r)
      4'd0:    op = {ax[15], ax};
      4'd1:    op = {ay[15], ay};
      4'd2:    op = {az[15], az};
      4'd3:    op = gyro_ok ? {rx[15], rx} : 17'sd0;
      4'd4:    op = gyro_ok ? {ry[15], ry} : 17'sd0;
      4'd5:    op = gyro_ok ? {rz[15], rz} : 17'sd0;
      4'd6:    op = $signed(ONE_G + {5'd0, cfg.moved_delta});
      4'd7:    op = $signed(ONE_G - {5'd0, cfg.moved_delta});
      4'd8:    op = $signed({2'd0, cfg.moved_rate});
      4'd9:    op = $signed(ONE_G + {5'd0, cfg.shake_delta});
      4'd10:   op = $signed(ONE_G - {5'd0, cfg.shake_delta});
      4'd11:   op = $signed({2'd0, cfg.shake_rate});
      default: op = 17'sd0;
    endcase
  end

  assign sq  = op * op;
  assign tag = step_r - 4'd1;

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 4'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= 4'd0;
    end else if (busy_r) begin
      if (step_r == STEP_DONE) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + 4'd1;
      end
    end
  end

  // Register the square, then accumulate or compare against the sums
  always_ff @(posedge clk) begin
    prod_r <= sq[30:0];
    if (start) begin
      acc_r   <= 32'd0;
      gyr_r   <= 32'd0;
      moved_r <= 1'b0;
      shake_r <= 1'b0;
    end else if (busy_r && step_r != 4'd0 && step_r != STEP_DONE) begin
      case (tag)
        4'd0, 4'd1, 4'd2: acc_r   <= acc_r + {1'b0, prod_r};
        4'd3, 4'd4, 4'd5: gyr_r   <= gyr_r + {1'b0, prod_r};
        4'd6:             moved_r <= moved_r | (acc_r >= {1'b0, prod_r});
        4'd7:             moved_r <= moved_r | (acc_r <= {1'b0, prod_r});
        4'd8:             moved_r <= moved_r | (gyr_r >= {1'b0, prod_r});
        4'd9:             shake_r <= shake_r | (acc_r >= {1'b0, prod_r});
        4'd10:            shake_r <= shake_r | (acc_r <= {1'b0, prod_r});
        4'd11:            shake_r <= shake_r | (gyr_r >= {1'b0, prod_r});
        default:          acc_r   <= acc_r;
      endcase
    end
  end

  assign status.busy   = busy_r;
  assign status.done   = busy_r && (step_r == STEP_DONE);
  assign status.moving = moved_r;
  assign status.shake  = shake_r;

endmodule

[sv/input_event_qualifier_log_top.sv]
// Channel   Beat                        Handshake
// in_       one sample or request       in_valid / in_ready
// out_      one result per input beat   out_valid / out_ready
// cfg_      register index and data     cfg_valid / cfg_ready (always ready)
//
// Touch, button, read, clear and unknown requests pass S_DECODE, then S_DONE;
// an enabled IMU sample passes S_MOTION in between, where the single shared
// squarer works through six axis and six threshold squares one per cycle.
// Reset is synchronous on rst_n low; the ring memory contents are not cleared.
// A new beat is taken while a finished result waits; out_ready low holds the
// next result in S_DONE.
module input_event_qualifier_log_top
  import ieq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [31:0]        in_now_ms,
  input  logic [1:0]         in_sample_valid,
  input  logic [2:0]         in_held_bits,
  input  logic [2:0]         in_click_bits,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  input  logic [3:0]         in_event_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_event_flag,
  output logic [31:0]        out_event_number,
  output logic [2:0]         out_event_kind,
  output logic [31:0]        out_event_time,
  output logic signed [15:0] out_event_x,
  output logic signed [15:0] out_event_y,
  output logic               out_touch_active,
  output logic               out_button_active,
  output logic               out_imu_moving,
  output logic [4:0]         out_stored_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

`include "assert_macros.svh"

  state_t         state_r, state_nxt;
  item_t          item_r;
  motion_cfg_t    mot_cfg;
  motion_status_t mot_st;
  logic           mot_start;

  logic [15:0] touch_hold_r, button_hold_r, imu_hold_r;
  logic [11:0] moved_delta_r, shake_delta_r;
  logic [14:0] moved_rate_r, shake_rate_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [31:0]      next_number_r;
  logic [31:0]      last_touch_r, last_button_r, last_imu_r;
  logic [2:0]       flags_r, flags_nxt;

  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  ring_entry_t      wr_entry, rd_entry;
  logic [PTR_W:0]   rd_sum, wr_sum;

  logic commit, out_free, have_read;
  logic push_en;
  logic [2:0]  push_kind;
  logic [31:0] push_coords;

  logic               out_valid_r;
  logic               out_flag_r;
  logic [31:0]        out_number_r;
  logic [2:0]         out_kind_r;
  logic [31:0]        out_time_r;
  logic signed [15:0] out_x_r, out_y_r;
  logic [2:0]         out_flags_r;
  logic [4:0]         out_count_r;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_hold_r  <= RST_TOUCH_HOLDOFF;
      button_hold_r <= RST_BUTTON_HOLDOFF;
      imu_hold_r    <= RST_IMU_HOLDOFF;
      moved_delta_r <= RST_MOVED_ACCEL;
      shake_delta_r <= RST_SHAKE_ACCEL;
      moved_rate_r  <= RST_MOVED_GYRO;
      shake_rate_r  <= RST_SHAKE_GYRO;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOUCH_HOLDOFF:  touch_hold_r  <= cfg_data;
        CFG_BUTTON_HOLDOFF: button_hold_r <= cfg_data;
        CFG_IMU_HOLDOFF:    imu_hold_r    <= cfg_data;
        CFG_MOVED_ACCEL:    moved_delta_r <= cfg_data[11:0];
        CFG_SHAKE_ACCEL:    shake_delta_r <= cfg_data[11:0];
        CFG_MOVED_GYRO:     moved_rate_r  <= cfg_data[14:0];
        CFG_SHAKE_GYRO:     shake_rate_r  <= cfg_data[14:0];
        default:            touch_hold_r  <= touch_hold_r;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.req   <= in_req_type;
      item_r.now   <= in_now_ms;
      item_r.valid <= in_sample_valid;
      item_r.held  <= in_held_bits;
      item_r.click <= in_click_bits;
      item_r.ax    <= in_axis_x;
      item_r.ay    <= in_axis_y;
      item_r.az    <= in_axis_z;
      item_r.rx    <= in_rate_x;
      item_r.ry    <= in_rate_y;
      item_r.rz    <= in_rate_z;
      item_r.idx   <= in_event_index;
    end
  end

  // Motion classifier
  assign mot_cfg.moved_delta = moved_delta_r;
  assign mot_cfg.shake_delta = shake_delta_r;
  assign mot_cfg.moved_rate  = moved_rate_r;
  assign mot_cfg.shake_rate  = shake_rate_r;

  ieq_motion u_motion (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mot_start),
    .gyro_ok (item_r.valid[1]),
    .ax      (item_r.ax),
    .ay      (item_r.ay),
    .az      (item_r.az),
    .rx      (item_r.rx),
    .ry      (item_r.ry),
    .rz      (item_r.rz),
    .cfg     (mot_cfg),
    .status  (mot_st)
  );

  // Ring addressing: age index and push slot, both modulo the depth
  assign have_read = (item_r.req == REQ_READ) &&
                     ((CNT_W + 4)'(item_r.idx) < (CNT_W + 4)'(fill_r));
  assign rd_sum    = {1'b0, head_r} + (PTR_W + 1)'(item_r.idx);
  assign wr_sum    = {1'b0, head_r} + (PTR_W + 1)'(fill_r);
  assign ram_raddr = (rd_sum >= (PTR_W + 1)'(RING_DEPTH)) ?
                     PTR_W'(rd_sum - (PTR_W + 1)'(RING_DEPTH)) : rd_sum[PTR_W-1:0];
  assign ram_waddr = (wr_sum >= (PTR_W + 1)'(RING_DEPTH)) ?
                     PTR_W'(wr_sum - (PTR_W + 1)'(RING_DEPTH)) : wr_sum[PTR_W-1:0];

  assign wr_entry.id     = next_number_r;
  assign wr_entry.stamp  = item_r.now;
  assign wr_entry.kind   = push_kind;
  assign wr_entry.coords = push_coords;
  assign rd_entry        = ring_entry_t'(ram_rdata);
  assign ram_we          = commit && push_en;

  ieq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = (item_r.req == REQ_IMU && item_r.valid[0]) ? S_MOTION : S_DONE;
      S_MOTION: if (mot_st.done) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // State outputs
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    in_ready  = 1'b0;
    mot_start = 1'b0;
    ram_re    = 1'b0;
    commit    = 1'b0;
    case (state_r)
      S_IDLE:   in_ready  = 1'b1;
      S_DECODE: begin
        mot_start = (item_r.req == REQ_IMU) && item_r.valid[0];
        ram_re    = have_read;
      end
      S_MOTION: mot_start = 1'b0;
      S_DONE:   commit    = out_free;
      default:  commit    = 1'b0;
    endcase
  end

  // Qualify the sample: activity flags, the event to push and the ring clear
  always_comb begin
    flags_nxt   = flags_r;
    push_en     = 1'b0;
    push_kind   = KIND_TOUCH;
    push_coords = 32'd0;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    case (item_r.req)
      REQ_TOUCH: begin
        flags_nxt[0] = item_r.valid[0] & item_r.held[0];
        if (item_r.valid[0] && item_r.click[0] &&
            time_passed(item_r.now, last_touch_r, touch_hold_r)) begin
          push_en     = 1'b1;
          push_coords = {item_r.ay, item_r.ax};
        end
      end
      REQ_BUTTON: begin
        flags_nxt[1] = |item_r.held;
        if ((|item_r.click) && time_passed(item_r.now, last_button_r, button_hold_r)) begin
          push_en   = 1'b1;
          push_kind = item_r.click[0] ? KIND_BTN_A :
                      (item_r.click[1] ? KIND_BTN_B : KIND_BTN_C);
        end
      end
      REQ_IMU: begin
        flags_nxt[2] = item_r.valid[0] & mot_st.moving;
        if (item_r.valid[0] && mot_st.moving &&
            time_passed(item_r.now, last_imu_r, imu_hold_r)) begin
          push_en   = 1'b1;
          push_kind = mot_st.shake ? KIND_SHAKE : KIND_MOVED;
        end
      end
      REQ_CLEAR: begin
        head_nxt = '0;
        fill_nxt = '0;
      end
      default: flags_nxt = flags_r;
    endcase
    // Full ring drops its oldest entry
    if (push_en) begin
      if (fill_r == CNT_W'(RING_DEPTH)) begin
        head_nxt = (head_r == PTR_W'(RING_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      end else begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  // Commit ring and qualifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      fill_r        <= '0;
      next_number_r <= 32'd0;
      last_touch_r  <= 32'd0;
      last_button_r <= 32'd0;
      last_imu_r    <= 32'd0;
      flags_r       <= 3'd0;
    end else if (commit) begin
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      flags_r <= flags_nxt;
      if (push_en) begin
        next_number_r <= next_number_r + 32'd1;
        case (item_r.req)
          REQ_TOUCH:  last_touch_r  <= item_r.now;
          REQ_BUTTON: last_button_r <= item_r.now;
          REQ_IMU:    last_imu_r    <= item_r.now;
          default:    last_imu_r    <= last_imu_r;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_flag_r  <= push_en | have_read;
      out_flags_r <= flags_nxt;
      out_count_r <= 5'(fill_nxt);
      if (push_en) begin
        out_number_r <= next_number_r;
        out_kind_r   <= push_kind;
        out_time_r   <= item_r.now;
        out_x_r      <= push_coords[15:0];
        out_y_r      <= push_coords[31:16];
      end else if (have_read) begin
        out_number_r <= rd_entry.id;
        out_kind_r   <= rd_entry.kind;
        out_time_r   <= rd_entry.stamp;
        out_x_r      <= rd_entry.coords[15:0];
        out_y_r      <= rd_entry.coords[31:16];
      end else begin
        out_number_r <= 32'd0;
        out_kind_r   <= 3'd0;
        out_time_r   <= 32'd0;
        out_x_r      <= 16'sd0;
        out_y_r      <= 16'sd0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_flag    = out_flag_r;
  assign out_event_number  = out_number_r;
  assign out_event_kind    = out_kind_r;
  assign out_event_time    = out_time_r;
  assign out_event_x       = out_x_r;
  assign out_event_y       = out_y_r;
  assign out_touch_active  = out_flags_r[0];
  assign out_button_active = out_flags_r[1];
  assign out_imu_moving    = out_flags_r[2];
  assign out_stored_count  = out_count_r;

  // Checks
  `ASSERT_NEVER(a_fill_range, fill_r > CNT_W'(RING_DEPTH), "ring fill beyond depth")
  `ASSERT_ALWAYS(a_push_bumps_id,
                 ram_we |=> (next_number_r == $past(next_number_r) + 32'd1),
                 "event id not advanced on push")
  `ASSERT_ALWAYS(a_motion_in_state,
                 mot_st.busy |-> (state_r == S_MOTION),
                 "classifier busy outside motion state")

endmodule

[test/event_log_checker.sv]
module event_log_checker
  import ieq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [31:0]        in_now_ms,
  input  logic [1:0]         in_sample_valid,
  input  logic [2:0]         in_held_bits,
  input  logic [2:0]         in_click_bits,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  input  logic [3:0]         in_event_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_event_flag,
  input  logic [31:0]        out_event_number,
  input  logic [2:0]         out_event_kind,
  input  logic [31:0]        out_event_time,
  input  logic signed [15:0] out_event_x,
  input  logic signed [15:0] out_event_y,
  input  logic               out_touch_active,
  input  logic               out_button_active,
  input  logic               out_imu_moving,
  input  logic [4:0]         out_stored_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result beat
  typedef struct packed {
    logic        flag;
    logic [31:0] number;
    logic [2:0]  kind;
    logic [31:0] stamp;
    logic [15:0] x;
    logic [15:0] y;
    logic        touch;
    logic        button;
    logic        moving;
    logic [4:0]  count;
  } event_report_t;

  // Shadow copy of the event ring and qualifier state
  logic [31:0]      log_id    [RING_DEPTH];
  logic [31:0]      log_stamp [RING_DEPTH];
  logic [2:0]       log_kind  [RING_DEPTH];
  logic [31:0]      log_xy    [RING_DEPTH];
  logic [PTR_W-1:0] log_head;
  logic [CNT_W-1:0] log_fill;
  logic [31:0]      next_id;
  logic [31:0]      last_touch;
  logic [31:0]      last_button;
  logic [31:0]      last_imu;
  logic             touch_on;
  logic             button_on;
  logic             moving_on;

  // Shadow copy of the registers
  logic [15:0] touch_hold;
  logic [15:0] button_hold;
  logic [15:0] imu_hold;
  logic [11:0] moved_delta;
  logic [11:0] shake_delta;
  logic [14:0] moved_rate;
  logic [14:0] shake_rate;

  event_report_t reports_due[$];
  event_report_t want;
  item_t         beat;

  assign beat = {in_req_type, in_now_ms, in_sample_valid, in_held_bits, in_click_bits,
                 in_axis_x, in_axis_y, in_axis_z, in_rate_x, in_rate_y, in_rate_z,
                 in_event_index};

  initial fail_count = 0;

  // Zero last time means the source never fired
  function automatic logic holdoff_over(input logic [31:0] now, input logic [31:0] last,
                                        input logic [15:0] hold);
    logic [31:0] gap;
    gap = now - last;
    if (last == 32'd0)
      return 1'b1;
    return gap >= 32'(hold);
  endfunction

  function automatic logic [63:0] sq_sum(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input logic signed [15:0] c);
    longint sa;
    longint sb;
    longint sc;
    sa = a;
    sb = b;
    sc = c;
    return 64'(sa * sa + sb * sb + sc * sc);
  endfunction

  // Compare squared magnitudes against squared thresholds
  function automatic logic exceeds(input logic [63:0] acc, input logic [63:0] gyr,
                                   input logic [11:0] d, input logic [14:0] r);
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] rr;
    hi = 64'(13'd4096 + 13'(d));
    lo = 64'(13'd4096 - 13'(d));
    hi = hi * hi;
    lo = lo * lo;
    rr = 64'(r) * 64'(r);
    return (acc >= hi) || (acc <= lo) || (gyr >= rr);
  endfunction

  // Append one event, overwriting the oldest when the ring is full
  function automatic logic [PTR_W-1:0] store_event(input logic [2:0] kind,
                                                   input logic [31:0] stamp,
                                                   input logic [31:0] xy);
    logic [PTR_W-1:0] pos;
    pos = log_head + log_fill[PTR_W-1:0];
    log_id[pos]    = next_id;
    log_stamp[pos] = stamp;
    log_kind[pos]  = kind;
    log_xy[pos]    = xy;
    next_id = next_id + 32'd1;
    if (log_fill < CNT_W'(RING_DEPTH))
      log_fill = log_fill + 1'b1;
    else
      log_head = log_head + 1'b1;
    return pos;
  endfunction

  // Advance the shadow state by one input beat and build its result
  function automatic event_report_t qualify_item(input item_t it);
    logic             hit;
    logic [PTR_W-1:0] pos;
    logic [63:0]      acc;
    logic [63:0]      gyr;
    logic             moving;
    logic [2:0]       kind;
    event_report_t    r;
    hit = 1'b0;
    pos = '0;
    case (it.req)
      REQ_TOUCH: begin
        if (!it.valid[0]) begin
          touch_on = 1'b0;
        end else begin
          touch_on = it.held[0];
          if (it.click[0] && holdoff_over(it.now, last_touch, touch_hold)) begin
            last_touch = it.now;
            pos = store_event(KIND_TOUCH, it.now, {it.ay, it.ax});
            hit = 1'b1;
          end
        end
      end
      REQ_BUTTON: begin
        button_on = |it.held;
        if ((|it.click) && holdoff_over(it.now, last_button, button_hold)) begin
          kind = it.click[0] ? KIND_BTN_A : (it.click[1] ? KIND_BTN_B : KIND_BTN_C);
          last_button = it.now;
          pos = store_event(kind, it.now, 32'd0);
          hit = 1'b1;
        end
      end
      REQ_IMU: begin
        if (!it.valid[0]) begin
          moving_on = 1'b0;
        end else begin
          acc = sq_sum(it.ax, it.ay, it.az);
          gyr = it.valid[1] ? sq_sum(it.rx, it.ry, it.rz) : 64'd0;
          moving = exceeds(acc, gyr, moved_delta, moved_rate);
          moving_on = moving;
          if (moving && holdoff_over(it.now, last_imu, imu_hold)) begin
            kind = exceeds(acc, gyr, shake_delta, shake_rate) ? KIND_SHAKE : KIND_MOVED;
            last_imu = it.now;
            pos = store_event(kind, it.now, 32'd0);
            hit = 1'b1;
          end
        end
      end
      REQ_READ: begin
        if (CNT_W'(it.idx) < log_fill) begin
          pos = log_head + it.idx;
          hit = 1'b1;
        end
      end
      REQ_CLEAR: begin
        log_head = '0;
        log_fill = '0;
      end
      default: ;
    endcase
    r.flag   = hit;
    r.number = hit ? log_id[pos] : 32'd0;
    r.kind   = hit ? log_kind[pos] : 3'd0;
    r.stamp  = hit ? log_stamp[pos] : 32'd0;
    r.x      = hit ? log_xy[pos][15:0] : 16'd0;
    r.y      = hit ? log_xy[pos][31:16] : 16'd0;
    r.touch  = touch_on;
    r.button = button_on;
    r.moving = moving_on;
    r.count  = 5'(log_fill);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Track register writes, compare result beats, predict input beats
  always @(posedge clk) begin
    if (!rst_n) begin
      log_head    = '0;
      log_fill    = '0;
      next_id     = 32'd0;
      last_touch  = 32'd0;
      last_button = 32'd0;
      last_imu    = 32'd0;
      touch_on    = 1'b0;
      button_on   = 1'b0;
      moving_on   = 1'b0;
      touch_hold  = RST_TOUCH_HOLDOFF;
      button_hold = RST_BUTTON_HOLDOFF;
      imu_hold    = RST_IMU_HOLDOFF;
      moved_delta = RST_MOVED_ACCEL;
      shake_delta = RST_SHAKE_ACCEL;
      moved_rate  = RST_MOVED_GYRO;
      shake_rate  = RST_SHAKE_GYRO;
      reports_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOUCH_HOLDOFF:  touch_hold  = cfg_data;
          CFG_BUTTON_HOLDOFF: button_hold = cfg_data;
          CFG_IMU_HOLDOFF:    imu_hold    = cfg_data;
          CFG_MOVED_ACCEL:    moved_delta = cfg_data[11:0];
          CFG_SHAKE_ACCEL:    shake_delta = cfg_data[11:0];
          CFG_MOVED_GYRO:     moved_rate  = cfg_data[14:0];
          CFG_SHAKE_GYRO:     shake_rate  = cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          check_field("event_flag", 32'(want.flag), 32'(out_event_flag));
          check_field("event_number", want.number, out_event_number);
          check_field("event_kind", 32'(want.kind), 32'(out_event_kind));
          check_field("event_time", want.stamp, out_event_time);
          check_field("event_x", 32'(want.x), 32'($unsigned(out_event_x)));
          check_field("event_y", 32'(want.y), 32'($unsigned(out_event_y)));
          check_field("touch_active", 32'(want.touch), 32'(out_touch_active));
          check_field("button_active", 32'(want.button), 32'(out_button_active));
          check_field("imu_moving", 32'(want.moving), 32'(out_imu_moving));
          check_field("stored_count", 32'(want.count), 32'(out_stored_count));
        end
      end
      if (in_valid && in_ready)
        reports_due.push_back(qualify_item(beat));
    end
    pending <= reports_due.size();
  end

endmodule

[test/testbench.sv]
module testbench;
  import ieq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int RANDOM_PER_PHASE = 165;
  localparam int PHASES           = 6;
  localparam int STALL_CYCLES     = 400;
  localparam int SETTLE_CYCLES    = 20;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_req_type;
  logic [31:0]        in_now_ms;
  logic [1:0]         in_sample_valid;
  logic [2:0]         in_held_bits;
  logic [2:0]         in_click_bits;
  logic signed [15:0] in_axis_x;
  logic signed [15:0] in_axis_y;
  logic signed [15:0] in_axis_z;
  logic signed [15:0] in_rate_x;
  logic signed [15:0] in_rate_y;
  logic signed [15:0] in_rate_z;
  logic [3:0]         in_event_index;
  logic               out_valid;
  logic               out_ready;
  logic               out_event_flag;
  logic [31:0]        out_event_number;
  logic [2:0]         out_event_kind;
  logic [31:0]        out_event_time;
  logic signed [15:0] out_event_x;
  logic signed [15:0] out_event_y;
  logic               out_touch_active;
  logic               out_button_active;
  logic               out_imu_moving;
  logic [4:0]         out_stored_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  int          fail_count;
  int          pending;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        rx_stall_req;
  int          quiet_cycles;
  logic [31:0] stamp_ms;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  input_event_qualifier_log_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_now_ms         (in_now_ms),
    .in_sample_valid   (in_sample_valid),
    .in_held_bits      (in_held_bits),
    .in_click_bits     (in_click_bits),
    .in_axis_x         (in_axis_x),
    .in_axis_y         (in_axis_y),
    .in_axis_z         (in_axis_z),
    .in_rate_x         (in_rate_x),
    .in_rate_y         (in_rate_y),
    .in_rate_z         (in_rate_z),
    .in_event_index    (in_event_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_flag    (out_event_flag),
    .out_event_number  (out_event_number),
    .out_event_kind    (out_event_kind),
    .out_event_time    (out_event_time),
    .out_event_x       (out_event_x),
    .out_event_y       (out_event_y),
    .out_touch_active  (out_touch_active),
    .out_button_active (out_button_active),
    .out_imu_moving    (out_imu_moving),
    .out_stored_count  (out_stored_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  event_log_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_now_ms         (in_now_ms),
    .in_sample_valid   (in_sample_valid),
    .in_held_bits      (in_held_bits),
    .in_click_bits     (in_click_bits),
    .in_axis_x         (in_axis_x),
    .in_axis_y         (in_axis_y),
    .in_axis_z         (in_axis_z),
    .in_rate_x         (in_rate_x),
    .in_rate_y         (in_rate_y),
    .in_rate_z         (in_rate_z),
    .in_event_index    (in_event_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_flag    (out_event_flag),
    .out_event_number  (out_event_number),
    .out_event_kind    (out_event_kind),
    .out_event_time    (out_event_time),
    .out_event_x       (out_event_x),
    .out_event_y       (out_event_y),
    .out_touch_active  (out_touch_active),
    .out_button_active (out_button_active),
    .out_imu_moving    (out_imu_moving),
    .out_stored_count  (out_stored_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Drop the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (rx_stall_req) begin
        rx_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic item_t make_item(input logic [2:0] req, input logic [31:0] now,
                                      input logic [1:0] sv, input logic [2:0] held,
                                      input logic [2:0] click, input logic [15:0] ax,
                                      input logic [15:0] ay, input logic [15:0] az,
                                      input logic [15:0] rx, input logic [15:0] ry,
                                      input logic [15:0] rz, input logic [3:0] idx);
    return {req, now, sv, held, click, ax, ay, az, rx, ry, rz, idx};
  endfunction

  // Random beat: noise in every field, then shape the fields the request uses
  function automatic item_t random_item();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 70)
      stamp_ms = stamp_ms + $urandom_range(400);
    else if (pick < 88)
      stamp_ms = stamp_ms + $urandom_range(70000);
    else if (pick < 96)
      stamp_ms = $urandom;
    else if (pick < 98)
      stamp_ms = 32'd0;
    else
      stamp_ms = 32'hFFFF_FFFF - $urandom_range(300);
    it.now   = stamp_ms;
    it.valid = 2'($urandom);
    it.held  = 3'($urandom);
    it.click = 3'($urandom);
    it.ax    = 16'($urandom);
    it.ay    = 16'($urandom);
    it.az    = 16'($urandom);
    it.rx    = 16'($urandom);
    it.ry    = 16'($urandom);
    it.rz    = 16'($urandom);
    it.idx   = 4'($urandom);
    pick = $urandom_range(99);
    if (pick < 24) begin
      it.req = REQ_TOUCH;
      it.valid[0] = ($urandom_range(99) < 85);
    end else if (pick < 44) begin
      it.req = REQ_BUTTON;
    end else if (pick < 74) begin
      it.req = REQ_IMU;
      it.valid[0] = ($urandom_range(99) < 85);
      // Keep most samples near 1 g so the thresholds decide
      if ($urandom_range(99) < 80) begin
        it.ax = 16'(int'($urandom_range(2400)) - 1200);
        it.ay = 16'(int'($urandom_range(2400)) - 1200);
        it.az = 16'(4096 + int'($urandom_range(7600)) - 3800);
      end
      if ($urandom_range(99) < 75) begin
        it.rx = 16'(int'($urandom_range(6000)) - 3000);
        it.ry = 16'(int'($urandom_range(6000)) - 3000);
        it.rz = 16'(int'($urandom_range(6000)) - 3000);
      end
    end else if (pick < 95) begin
      it.req = REQ_READ;
    end else if (pick < 97) begin
      it.req = REQ_CLEAR;
    end else begin
      it.req = 3'($urandom_range(7, 5));
    end
    return it;
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_beat(input item_t it);
    in_valid        <= 1'b1;
    in_req_type     <= it.req;
    in_now_ms       <= it.now;
    in_sample_valid <= it.valid;
    in_held_bits    <= it.held;
    in_click_bits   <= it.click;
    in_axis_x       <= it.ax;
    in_axis_y       <= it.ay;
    in_axis_z       <= it.az;
    in_rate_x       <= it.rx;
    in_rate_y       <= it.ry;
    in_rate_z       <= it.rz;
    in_event_index  <= it.idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic offer(input item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    send_beat(it);
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Program all registers while the block is idle
  task automatic program_registers(input logic [15:0] t_hold, input logic [15:0] b_hold,
                                   input logic [15:0] i_hold, input logic [11:0] m_delta,
                                   input logic [11:0] s_delta, input logic [14:0] m_rate,
                                   input logic [14:0] s_rate);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_TOUCH_HOLDOFF, t_hold);
    write_reg(CFG_BUTTON_HOLDOFF, b_hold);
    write_reg(CFG_IMU_HOLDOFF, i_hold);
    write_reg(CFG_MOVED_ACCEL, 16'(m_delta));
    write_reg(CFG_SHAKE_ACCEL, 16'(s_delta));
    write_reg(CFG_MOVED_GYRO, 16'(m_rate));
    write_reg(CFG_SHAKE_GYRO, 16'(s_rate));
    cfg_valid <= 1'b0;
  endtask

  // Defaults: edges of the hold-offs, every button, idle/moved/shake, reads
  task automatic run_directed();
    offer(make_item(REQ_READ, 32'd0, 2'b00, 3'b000, 3'b000, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    // touch disabled: clear activity, ignore the click
    offer(make_item(REQ_TOUCH, 32'd10, 2'b10, 3'b111, 3'b111, 16'h7FFF, 16'h8000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF));
    offer(make_item(REQ_TOUCH, 32'd0, 2'b01, 3'b001, 3'b001, 16'h7FFF, 16'h8000,
                    16'h0, 16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_TOUCH, 32'd100, 2'b11, 3'b001, 3'b001, 16'h8000, 16'h7FFF,
                    16'h0, 16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_TOUCH, 32'd250, 2'b01, 3'b000, 3'b001, 16'h0001, 16'hFFFF,
                    16'h0, 16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_TOUCH, 32'd300, 2'b01, 3'b110, 3'b111, 16'h1234, 16'hFEDC,
                    16'h0, 16'h0, 16'h0, 16'h0, 4'd0));
    // several buttons clicked: A wins, then B, then C
    offer(make_item(REQ_BUTTON, 32'd1000, 2'b00, 3'b111, 3'b111, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_BUTTON, 32'd1100, 2'b00, 3'b010, 3'b110, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_BUTTON, 32'd1300, 2'b11, 3'b000, 3'b110, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_BUTTON, 32'd1600, 2'b00, 3'b100, 3'b100, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    // imu invalid, then gyro invalid at rest
    offer(make_item(REQ_IMU, 32'd2000, 2'b10, 3'b111, 3'b111, 16'h8000, 16'h8000,
                    16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'd0));
    offer(make_item(REQ_IMU, 32'd3000, 2'b01, 3'b000, 3'b000, 16'h0, 16'h0, 16'd4096,
                    16'h8000, 16'h7FFF, 16'h8000, 4'd0));
    offer(make_item(REQ_IMU, 32'd4000, 2'b11, 3'b000, 3'b000, 16'h0, 16'h0, 16'd4096,
                    16'd560, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_IMU, 32'd5000, 2'b01, 3'b000, 3'b000, 16'h8000, 16'h8000,
                    16'h8000, 16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_IMU, 32'd5500, 2'b01, 3'b000, 3'b000, 16'h7FFF, 16'h7FFF,
                    16'h7FFF, 16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_IMU, 32'd7000, 2'b01, 3'b000, 3'b000, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_IMU, 32'd9000, 2'b11, 3'b000, 3'b000, 16'h0, 16'h0, 16'd4096,
                    16'h8000, 16'h7FFF, 16'h8000, 4'd0));
    offer(make_item(REQ_READ, 32'd9001, 2'b00, 3'b000, 3'b000, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_READ, 32'd9002, 2'b00, 3'b000, 3'b000, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd5));
    offer(make_item(REQ_READ, 32'd9003, 2'b00, 3'b000, 3'b000, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd15));
    offer(make_item(3'd5, 32'd9004, 2'b11, 3'b111, 3'b111, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(3'd7, 32'hFFFF_FFFF, 2'b11, 3'b111, 3'b111, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF));
    offer(make_item(REQ_CLEAR, 32'd9005, 2'b00, 3'b000, 3'b000, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_READ, 32'd9006, 2'b00, 3'b000, 3'b000, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 16'h0, 4'd0));
    // hold-off measured across the timestamp wrap
    offer(make_item(REQ_TOUCH, 32'hFFFF_FF00, 2'b01, 3'b001, 3'b001, 16'h0042, 16'h0099,
                    16'h0, 16'h0, 16'h0, 16'h0, 4'd0));
    offer(make_item(REQ_TOUCH, 32'h0000_0010, 2'b01, 3'b001, 3'b001, 16'hFF00, 16'h00FF,
                    16'h0, 16'h0, 16'h0, 16'h0, 4'd0));
  endtask

  // Stimulus and verdict
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = REQ_TOUCH;
    in_now_ms       = 32'd0;
    in_sample_valid = 2'b00;
    in_held_bits    = 3'b000;
    in_click_bits   = 3'b000;
    in_axis_x       = 16'sd0;
    in_axis_y       = 16'sd0;
    in_axis_z       = 16'sd0;
    in_rate_x       = 16'sd0;
    in_rate_y       = 16'sd0;
    in_rate_z       = 16'sd0;
    in_event_index  = 4'd0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_TOUCH_HOLDOFF;
    cfg_data        = 16'd0;
    rx_stall_req    = 1'b0;
    tx_idle_pct     = 26;
    rx_idle_pct     = 68;
    stamp_ms        = 32'd20000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_registers(16'd0, 16'd0, 16'd0, 12'd0, 12'd0, 15'd0, 15'd0);
        1: program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF,
                             15'h7FFF, 15'h7FFF);
        2: program_registers(RST_TOUCH_HOLDOFF, RST_BUTTON_HOLDOFF, RST_IMU_HOLDOFF,
                             RST_MOVED_ACCEL, RST_SHAKE_ACCEL, RST_MOVED_GYRO,
                             RST_SHAKE_GYRO);
        3: program_registers(16'($urandom), 16'($urandom), 16'($urandom),
                             12'($urandom), 12'($urandom), 15'($urandom), 15'($urandom));
        default: program_registers(16'($urandom_range(300)), 16'($urandom_range(300)),
                                   16'($urandom_range(600)), 12'($urandom_range(1500)),
                                   12'($urandom_range(4095)), 15'($urandom_range(3000)),
                                   15'($urandom_range(6000)));
      endcase
      // Idling: sender light/receiver heavy, then swapped, then none
      case (p / 2)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 68;
        end
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 4 && n == 60)
          rx_stall_req = 1'b1;
        if (p == 2 && n == 80)
          drain();
        offer(random_item());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/ieq_pkg.sv
sv/ieq_ram.sv
sv/ieq_motion.sv
sv/input_event_qualifier_log_top.sv
test/event_log_checker.sv
test/testbench.sv
